// File: src/complex_mul_div_unit_assert.svh
// ----------------------------------------------------------------------------
// complex_mul_div_unit assertion macros
// shared property forms for the complex multiply / divide unit checks
// ----------------------------------------------------------------------------
`ifndef COMPLEX_MUL_DIV_UNIT_ASSERT_SVH
`define COMPLEX_MUL_DIV_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define CMDU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cmdu same-cycle check failed");

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define CMDU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cmdu next-cycle check failed");

`endif

// File: src/cmdu_pkg.sv
// ----------------------------------------------------------------------------
// cmdu_pkg
// shared types and defaults of the complex multiply / divide unit
// ----------------------------------------------------------------------------
package cmdu_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // operation selector
  typedef enum logic [1:0] {
    ACT_MUL      = 2'd0,
    ACT_DIV      = 2'd1,
    ACT_DIV_REAL = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  // control carried beside the data down the pipeline
  typedef struct packed {
    action_e act;
    logic    dbz;
  } ctl_t;

endpackage

// File: src/cmdu_front.sv
// ----------------------------------------------------------------------------
// cmdu_front
// decode, partial products, signed sums and divider operand selection
// ----------------------------------------------------------------------------
module cmdu_front #(
  parameter int unsigned DATA_WIDTH = cmdu_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = cmdu_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [1:0]                            act_i,
  input  logic signed [DATA_WIDTH-1:0]          a_re_i,
  input  logic signed [DATA_WIDTH-1:0]          a_im_i,
  input  logic signed [DATA_WIDTH-1:0]          b_re_i,
  input  logic signed [DATA_WIDTH-1:0]          b_im_i,
  output logic                                  valid_o,
  output cmdu_pkg::ctl_t                        ctl_o,
  output logic [2*DATA_WIDTH+1+FRAC_BITS-1:0]   num_re_o,
  output logic [2*DATA_WIDTH+1+FRAC_BITS-1:0]   num_im_o,
  output logic                                  neg_re_o,
  output logic                                  neg_im_o,
  output logic [2*DATA_WIDTH:0]                 den_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned DW = 2 * W + 1;
  localparam int unsigned SW = 2 * W + 2;
  localparam int unsigned NW = DW + FRAC_BITS;

  function automatic logic signed [SW-1:0] sv(input logic neg, input logic [PW-1:0] p);
    logic signed [SW-1:0] x;
    x = signed'({2'b00, p});
    return neg ? -x : x;
  endfunction

  // stage 1: signs and magnitudes
  logic                v1_q;
  cmdu_pkg::action_e   act1_q;
  logic                arn1_q, ain1_q, brn1_q, bin1_q;
  logic [W-1:0]        arm1_q, aim1_q, brm1_q, bim1_q;

  // stage 2: products
  logic                v2_q;
  cmdu_pkg::action_e   act2_q;
  logic                arn2_q, ain2_q, brn2_q;
  logic                s_rr2_q, s_ii2_q, s_ri2_q, s_ir2_q;
  logic [W-1:0]        arm2_q, aim2_q, brm2_q;
  logic [PW-1:0]       p_rr2_q, p_ii2_q, p_ri2_q, p_ir2_q, p_bb2_q, p_jj2_q;

  // stage 3: signed sums and squared magnitude
  logic                v3_q;
  cmdu_pkg::action_e   act3_q;
  logic                arn3_q, ain3_q, brn3_q;
  logic [W-1:0]        arm3_q, aim3_q, brm3_q;
  logic signed [SW-1:0] sre3_q, sim3_q;
  logic [DW-1:0]       d3_q;

  // stage 4: divider operands
  logic                v4_q;
  cmdu_pkg::ctl_t      ctl4_q;
  logic [NW-1:0]       nre4_q, nim4_q;
  logic                nre_neg4_q, nim_neg4_q;
  logic [DW-1:0]       den4_q;

  logic signed [SW-1:0] sre_d, sim_d;
  logic [SW-1:0]        abs_re, abs_im;
  logic [DW-1:0]        mag_re, mag_im;
  cmdu_pkg::ctl_t       ctl_d;
  logic [NW-1:0]        nre_d, nim_d;
  logic                 nre_neg_d, nim_neg_d;
  logic [DW-1:0]        den_d;

  // sums for the two complex actions
  always_comb begin
    if (act2_q == cmdu_pkg::ACT_DIV) begin
      sre_d = sv(s_rr2_q, p_rr2_q) + sv(s_ii2_q, p_ii2_q);
      sim_d = sv(s_ir2_q, p_ir2_q) + sv(!s_ri2_q, p_ri2_q);
    end else begin
      sre_d = sv(s_rr2_q, p_rr2_q) + sv(!s_ii2_q, p_ii2_q);
      sim_d = sv(s_ri2_q, p_ri2_q) + sv(s_ir2_q, p_ir2_q);
    end
  end

  // magnitudes and operand select per action
  always_comb begin
    abs_re    = sre3_q[SW-1] ? SW'(-sre3_q) : SW'(sre3_q);
    abs_im    = sim3_q[SW-1] ? SW'(-sim3_q) : SW'(sim3_q);
    mag_re    = abs_re[DW-1:0];
    mag_im    = abs_im[DW-1:0];
    ctl_d.act = act3_q;
    ctl_d.dbz = 1'b0;
    nre_d     = NW'(mag_re);
    nim_d     = NW'(mag_im);
    nre_neg_d = sre3_q[SW-1];
    nim_neg_d = sim3_q[SW-1];
    den_d     = DW'(1) << FRAC_BITS;
    unique case (act3_q)
      cmdu_pkg::ACT_DIV: begin
        nre_d     = NW'(mag_re) << FRAC_BITS;
        nim_d     = NW'(mag_im) << FRAC_BITS;
        den_d     = d3_q;
        ctl_d.dbz = (d3_q == '0);
      end
      cmdu_pkg::ACT_DIV_REAL: begin
        nre_d     = NW'(arm3_q) << FRAC_BITS;
        nim_d     = NW'(aim3_q) << FRAC_BITS;
        nre_neg_d = arn3_q ^ brn3_q;
        nim_neg_d = ain3_q ^ brn3_q;
        den_d     = DW'(brm3_q);
        ctl_d.dbz = (brm3_q == '0);
      end
      default: begin
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // data stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act1_q <= cmdu_pkg::action_e'(act_i);
      arn1_q <= a_re_i[W-1];
      ain1_q <= a_im_i[W-1];
      brn1_q <= b_re_i[W-1];
      bin1_q <= b_im_i[W-1];
      arm1_q <= a_re_i[W-1] ? W'(-a_re_i) : W'(a_re_i);
      aim1_q <= a_im_i[W-1] ? W'(-a_im_i) : W'(a_im_i);
      brm1_q <= b_re_i[W-1] ? W'(-b_re_i) : W'(b_re_i);
      bim1_q <= b_im_i[W-1] ? W'(-b_im_i) : W'(b_im_i);

      act2_q  <= act1_q;
      arn2_q  <= arn1_q;
      ain2_q  <= ain1_q;
      brn2_q  <= brn1_q;
      arm2_q  <= arm1_q;
      aim2_q  <= aim1_q;
      brm2_q  <= brm1_q;
      s_rr2_q <= arn1_q ^ brn1_q;
      s_ii2_q <= ain1_q ^ bin1_q;
      s_ri2_q <= arn1_q ^ bin1_q;
      s_ir2_q <= ain1_q ^ brn1_q;
      p_rr2_q <= PW'(arm1_q) * PW'(brm1_q);
      p_ii2_q <= PW'(aim1_q) * PW'(bim1_q);
      p_ri2_q <= PW'(arm1_q) * PW'(bim1_q);
      p_ir2_q <= PW'(aim1_q) * PW'(brm1_q);
      p_bb2_q <= PW'(brm1_q) * PW'(brm1_q);
      p_jj2_q <= PW'(bim1_q) * PW'(bim1_q);

      act3_q <= act2_q;
      arn3_q <= arn2_q;
      ain3_q <= ain2_q;
      brn3_q <= brn2_q;
      arm3_q <= arm2_q;
      aim3_q <= aim2_q;
      brm3_q <= brm2_q;
      sre3_q <= sre_d;
      sim3_q <= sim_d;
      d3_q   <= DW'(p_bb2_q) + DW'(p_jj2_q);

      ctl4_q     <= ctl_d;
      nre4_q     <= nre_d;
      nim4_q     <= nim_d;
      nre_neg4_q <= nre_neg_d;
      nim_neg4_q <= nim_neg_d;
      den4_q     <= den_d;
    end
  end

  assign valid_o  = v4_q;
  assign ctl_o    = ctl4_q;
  assign num_re_o = nre4_q;
  assign num_im_o = nim4_q;
  assign neg_re_o = nre_neg4_q;
  assign neg_im_o = nim_neg4_q;
  assign den_o    = den4_q;

endmodule

// File: src/cmdu_div.sv
// ----------------------------------------------------------------------------
// cmdu_div
// two-lane restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
module cmdu_div #(
  parameter int unsigned DATA_WIDTH = cmdu_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = cmdu_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  cmdu_pkg::ctl_t                        ctl_i,
  input  logic [2*DATA_WIDTH+1+FRAC_BITS-1:0]   num_re_i,
  input  logic [2*DATA_WIDTH+1+FRAC_BITS-1:0]   num_im_i,
  input  logic                                  neg_re_i,
  input  logic                                  neg_im_i,
  input  logic [2*DATA_WIDTH:0]                 den_i,
  output logic                                  valid_o,
  output cmdu_pkg::ctl_t                        ctl_o,
  output logic [2*DATA_WIDTH+1+FRAC_BITS-1:0]   quo_re_o,
  output logic [2*DATA_WIDTH+1+FRAC_BITS-1:0]   quo_im_o,
  output logic                                  neg_re_o,
  output logic                                  neg_im_o
);

  localparam int unsigned DW = 2 * DATA_WIDTH + 1;
  localparam int unsigned NW = DW + FRAC_BITS;

  typedef struct packed {
    logic [DW-1:0] r;
    logic [NW-1:0] n;
    logic [NW-1:0] q;
  } lane_t;

  // one restoring step: shift in a numerator bit, subtract when it fits
  function automatic lane_t div_step(input lane_t x, input logic [DW-1:0] d);
    lane_t         y;
    logic [DW:0]   r2;
    logic [DW:0]   diff;
    logic          ge;
    r2   = {x.r, x.n[NW-1]};
    diff = r2 - {1'b0, d};
    ge   = (r2 >= {1'b0, d});
    y.r  = ge ? diff[DW-1:0] : r2[DW-1:0];
    y.n  = x.n << 1;
    y.q  = {x.q[NW-2:0], ge};
    return y;
  endfunction

  logic            v_q    [NW];
  cmdu_pkg::ctl_t  ctl_q  [NW];
  logic [DW-1:0]   den_q  [NW];
  logic            nre_q  [NW];
  logic            nim_q  [NW];
  lane_t           re_q   [NW];
  lane_t           im_q   [NW];

  lane_t re_in, im_in;

  always_comb begin
    re_in.r = '0;
    re_in.n = num_re_i;
    re_in.q = '0;
    im_in.r = '0;
    im_in.n = num_im_i;
    im_in.q = '0;
  end

  // first stage takes the operands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q[0] <= ctl_i;
      den_q[0] <= den_i;
      nre_q[0] <= neg_re_i;
      nim_q[0] <= neg_im_i;
      re_q[0]  <= div_step(re_in, den_i);
      im_q[0]  <= div_step(im_in, den_i);
    end
  end

  // remaining quotient bits, one stage each
  for (genvar k = 1; k < NW; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctl_q[k] <= ctl_q[k-1];
        den_q[k] <= den_q[k-1];
        nre_q[k] <= nre_q[k-1];
        nim_q[k] <= nim_q[k-1];
        re_q[k]  <= div_step(re_q[k-1], den_q[k-1]);
        im_q[k]  <= div_step(im_q[k-1], den_q[k-1]);
      end
    end
  end

  assign valid_o  = v_q[NW-1];
  assign ctl_o    = ctl_q[NW-1];
  assign quo_re_o = re_q[NW-1].q;
  assign quo_im_o = im_q[NW-1].q;
  assign neg_re_o = nre_q[NW-1];
  assign neg_im_o = nim_q[NW-1];

endmodule

// File: src/cmdu_out.sv
// ----------------------------------------------------------------------------
// cmdu_out
// saturation, flags, output register and skid stage
// ----------------------------------------------------------------------------
`include "complex_mul_div_unit_assert.svh"

module cmdu_out #(
  parameter int unsigned DATA_WIDTH = cmdu_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = cmdu_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  output logic                                  en_o,
  input  logic                                  valid_i,
  input  cmdu_pkg::ctl_t                        ctl_i,
  input  logic [2*DATA_WIDTH+1+FRAC_BITS-1:0]   quo_re_i,
  input  logic [2*DATA_WIDTH+1+FRAC_BITS-1:0]   quo_im_i,
  input  logic                                  neg_re_i,
  input  logic                                  neg_im_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [DATA_WIDTH-1:0]          res_re_o,
  output logic signed [DATA_WIDTH-1:0]          res_im_o,
  output logic                                  dbz_o,
  output logic                                  ovf_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned NW = 2 * W + 1 + FRAC_BITS;

  typedef struct packed {
    logic [W-1:0] re;
    logic [W-1:0] im;
    logic         dbz;
    logic         ovf;
  } res_t;

  // clamp a magnitude to the signed range, top bit is the overflow flag
  function automatic logic [W:0] sat(input logic neg, input logic [NW-1:0] q);
    logic [NW-1:0] lim;
    logic          ovf;
    logic [W-1:0]  m;
    lim = neg ? (NW'(1) << (W - 1)) : ((NW'(1) << (W - 1)) - NW'(1));
    ovf = (q > lim);
    m   = ovf ? lim[W-1:0] : q[W-1:0];
    return {ovf, neg ? -m : m};
  endfunction

  logic   out_v_q, out_v_d;
  logic   skid_v_q, skid_v_d;
  res_t   out_q, skid_q, res_d;
  logic   load_in, load_skid, load_from_skid;
  logic [W:0] sat_re, sat_im;

  // result formation
  always_comb begin
    sat_re = sat(neg_re_i, quo_re_i);
    sat_im = sat(neg_im_i, quo_im_i);
    res_d.dbz = ctl_i.dbz;
    if (ctl_i.dbz || (ctl_i.act == cmdu_pkg::ACT_NONE)) begin
      res_d.re  = '0;
      res_d.im  = '0;
      res_d.ovf = 1'b0;
    end else begin
      res_d.re  = sat_re[W-1:0];
      res_d.im  = sat_im[W-1:0];
      res_d.ovf = sat_re[W] | sat_im[W];
    end
  end

  // output register and skid control
  always_comb begin
    out_v_d        = out_v_q;
    skid_v_d       = skid_v_q;
    load_in        = 1'b0;
    load_skid      = 1'b0;
    load_from_skid = 1'b0;
    if (!out_v_q || ready_i) begin
      if (skid_v_q) begin
        load_from_skid = 1'b1;
        out_v_d        = 1'b1;
        skid_v_d       = 1'b0;
      end else if (valid_i) begin
        load_in = 1'b1;
        out_v_d = 1'b1;
      end else begin
        out_v_d = 1'b0;
      end
    end else if (valid_i && !skid_v_q) begin
      load_skid = 1'b1;
      skid_v_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_from_skid) begin
      out_q <= skid_q;
    end else if (load_in) begin
      out_q <= res_d;
    end
    if (load_skid) begin
      skid_q <= res_d;
    end
  end

  assign en_o     = !skid_v_q;
  assign valid_o  = out_v_q;
  assign res_re_o = out_q.re;
  assign res_im_o = out_q.im;
  assign dbz_o    = out_q.dbz;
  assign ovf_o    = out_q.ovf;

  // checks
  `CMDU_ASSERT_IMPL(a_skid_needs_out, skid_v_q, out_v_q)
  `CMDU_ASSERT_IMPL(a_dbz_gives_zero, out_v_q && out_q.dbz, {out_q.re, out_q.im, out_q.ovf} == '0)
  `CMDU_ASSERT_NEXT(a_skid_refills_out, skid_v_q && ready_i, out_v_q && !skid_v_q)

endmodule

// File: src/complex_mul_div_unit.sv
// ----------------------------------------------------------------------------
// complex_mul_div_unit
// fixed point complex multiply, complex divide and divide by real
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit up)              tuser
//  s_axis    in         a_re, a_im, b_re, b_im          action
//  m_axis    out        res_re, res_im                  div_by_zero, overflow
//
//  one request is taken every cycle while the skid stage is empty; the divider sets
//  most of the pipeline depth, with one stage per quotient bit
//  reset clears all valid bits at once; no clearing pass
//  the whole pipeline holds while the skid stage is full, so a stall drops nothing
// ----------------------------------------------------------------------------
module complex_mul_div_unit #(
  parameter int unsigned DATA_WIDTH = cmdu_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = cmdu_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // a_re, a_im, b_re, b_im
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]         s_axis_tdata_i,
  // action
  input  logic [1:0]                                s_axis_tuser_i,
  output logic                                      m_axis_tvalid_o,
  input  logic                                      m_axis_tready_i,
  // res_re, res_im
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]         m_axis_tdata_o,
  // div_by_zero, overflow
  output logic [1:0]                                m_axis_tuser_o
);

  localparam int unsigned W      = DATA_WIDTH;
  localparam int unsigned DW     = 2 * W + 1;
  localparam int unsigned NW     = DW + FRAC_BITS;
  localparam int unsigned TOUT_W = ((2 * W + 7) / 8) * 8;

  logic                 en;
  logic                 f_valid, d_valid;
  cmdu_pkg::ctl_t       f_ctl, d_ctl;
  logic [NW-1:0]        f_num_re, f_num_im, d_quo_re, d_quo_im;
  logic                 f_neg_re, f_neg_im, d_neg_re, d_neg_im;
  logic [DW-1:0]        f_den;
  logic signed [W-1:0]  res_re, res_im;
  logic                 dbz, ovf;

  cmdu_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid_i),
    .act_i    (s_axis_tuser_i),
    .a_re_i   (s_axis_tdata_i[W-1:0]),
    .a_im_i   (s_axis_tdata_i[2*W-1:W]),
    .b_re_i   (s_axis_tdata_i[3*W-1:2*W]),
    .b_im_i   (s_axis_tdata_i[4*W-1:3*W]),
    .valid_o  (f_valid),
    .ctl_o    (f_ctl),
    .num_re_o (f_num_re),
    .num_im_o (f_num_im),
    .neg_re_o (f_neg_re),
    .neg_im_o (f_neg_im),
    .den_o    (f_den)
  );

  cmdu_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (f_valid),
    .ctl_i    (f_ctl),
    .num_re_i (f_num_re),
    .num_im_i (f_num_im),
    .neg_re_i (f_neg_re),
    .neg_im_i (f_neg_im),
    .den_i    (f_den),
    .valid_o  (d_valid),
    .ctl_o    (d_ctl),
    .quo_re_o (d_quo_re),
    .quo_im_o (d_quo_im),
    .neg_re_o (d_neg_re),
    .neg_im_o (d_neg_im)
  );

  cmdu_out #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_o     (en),
    .valid_i  (d_valid),
    .ctl_i    (d_ctl),
    .quo_re_i (d_quo_re),
    .quo_im_i (d_quo_im),
    .neg_re_i (d_neg_re),
    .neg_im_i (d_neg_im),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .res_re_o (res_re),
    .res_im_o (res_im),
    .dbz_o    (dbz),
    .ovf_o    (ovf)
  );

  assign s_axis_tready_o = en;
  assign m_axis_tdata_o  = TOUT_W'({res_im, res_re});
  assign m_axis_tuser_o  = {ovf, dbz};

endmodule
